FILE: rtl/pfa_pkg.sv
package pfa_pkg;

  // Frame geometry
  localparam int FRAME_COUNT = 131072;
  localparam int FRAME_BYTES = 4096;
  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
  localparam int FRAME_W     = $clog2(FRAME_COUNT);

  // Bitmap word geometry
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WORDS     = FRAME_COUNT / WORD_BITS;
  localparam int WORD_AW   = $clog2(WORDS);

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 32;
  localparam int LIM_W   = 30;
  localparam int FADDR_W = 29;
  localparam int COUNT_W = 18;
  localparam int FS_W    = LIM_W + 1 - FRAME_SHIFT;

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(32'h0010_0000);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_RESERVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_SET_USED = 2'd1,
    OP_SET_FREE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_FINISH,
    S_REPLY
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
  } pfa_req_t;

  typedef struct packed {
    logic [FADDR_W-1:0] frame_address;
    status_t            status;
    logic [COUNT_W-1:0] free_count;
  } pfa_rsp_t;

  // Bitmap RAM access from the sequencer
  typedef struct packed {
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
  } mem_req_t;

  // Word unit result
  typedef struct packed {
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] changed;
    logic                 found;
    logic [BIT_W-1:0]     idx;
  } word_res_t;

endpackage

FILE: rtl/physical_frame_bitmap_allocator_top.sv
// Channel   Direction  Handshake               Payload
// in_       request    in_valid / in_ready     pfa_req_t (command, address, length)
// out_      result     out_valid / out_ready   pfa_rsp_t (frame_address, status, free_count)
// cfg_      write      cfg_wr_en               low reserve limit, 30 bits
//
// After reset a pass over all 2048 bitmap words presets the bitmap RAM to all used; no
// request is taken meanwhile. A request then walks bitmap words one after another:
// alloc walks from the limit's word to the first word with a free frame (up to 2048),
// range commands walk every word they cover, free touches one word. The bitmap RAM has a
// single read port, read one word per cycle. The result waits in an output register, so a
// new request is taken while out_ready is low.
module physical_frame_bitmap_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pfa_pkg::pfa_req_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pfa_pkg::pfa_rsp_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [pfa_pkg::LIM_W-1:0]     cfg_wr_data
);

  logic [pfa_pkg::LIM_W-1:0] lim_r;
  logic                      out_valid_r;
  pfa_pkg::pfa_rsp_t         out_data_r;
  logic                      rsp_valid;
  logic                      rsp_take;
  pfa_pkg::pfa_rsp_t         rsp;
  pfa_pkg::mem_req_t         mem;
  logic [pfa_pkg::WORD_BITS-1:0] mem_rd_data;

  // Hold the low reserve limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= pfa_pkg::LIM_RESET;
    end else if (cfg_wr_en) begin
      lim_r <= cfg_wr_data;
    end
  end

  // Output register: load when empty or being drained
  assign rsp_take = rsp_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pfa_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (in_valid),
    .req_ready         (in_ready),
    .req               (in_data),
    .low_reserve_limit (lim_r),
    .rsp_valid         (rsp_valid),
    .rsp_take          (rsp_take),
    .rsp               (rsp),
    .mem               (mem),
    .mem_rd_data       (mem_rd_data)
  );

  pfa_ram #(
    .WIDTH (pfa_pkg::WORD_BITS),
    .DEPTH (pfa_pkg::WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (mem.wr_en),
    .wr_addr (mem.wr_addr),
    .wr_data (mem.wr_data),
    .rd_en   (mem.rd_en),
    .rd_addr (mem.rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

FILE: rtl/pfa_ram.sv
module pfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/pfa_word_unit.sv
module pfa_word_unit (
  input  pfa_pkg::op_t                     op,
  input  logic [pfa_pkg::WORD_BITS-1:0]    word,
  input  logic [pfa_pkg::BIT_W-1:0]        lo,
  input  logic [pfa_pkg::BIT_W-1:0]        hi,
  output pfa_pkg::word_res_t               res
);

  logic [pfa_pkg::WORD_BITS-1:0] mask;
  logic [pfa_pkg::WORD_BITS-1:0] cand;
  logic [pfa_pkg::WORD_BITS-1:0] first;
  logic [pfa_pkg::BIT_W-1:0]     idx;

  // Build the bit window lo..hi of this word
  assign mask = ({pfa_pkg::WORD_BITS{1'b1}} << lo) &
                ({pfa_pkg::WORD_BITS{1'b1}} >> (pfa_pkg::BIT_W'(pfa_pkg::WORD_BITS - 1) - hi));

  // Isolate the lowest free frame inside the window
  assign cand  = ~word & mask;
  assign first = cand & (~cand + pfa_pkg::WORD_BITS'(1));

  // Encode the one-hot position
  always_comb begin
    idx = '0;
    for (int i = 0; i < pfa_pkg::WORD_BITS; i++) begin
      if (first[i]) begin
        idx = idx | pfa_pkg::BIT_W'(i);
      end
    end
  end

  // Apply the operation to the word
  always_comb begin
    res.found = |cand;
    res.idx   = idx;
    case (op)
      pfa_pkg::OP_ALLOC: begin
        res.new_word = word | first;
        res.changed  = first;
      end
      pfa_pkg::OP_SET_USED: begin
        res.new_word = word | mask;
        res.changed  = mask & ~word;
      end
      default: begin
        res.new_word = word & ~mask;
        res.changed  = mask & word;
      end
    endcase
  end

endmodule

FILE: rtl/pfa_ctrl.sv
module pfa_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  pfa_pkg::pfa_req_t                 req,
  input  logic [pfa_pkg::LIM_W-1:0]         low_reserve_limit,
  output logic                              rsp_valid,
  input  logic                              rsp_take,
  output pfa_pkg::pfa_rsp_t                 rsp,
  output pfa_pkg::mem_req_t                 mem,
  input  logic [pfa_pkg::WORD_BITS-1:0]     mem_rd_data
);

  localparam int FW  = pfa_pkg::FRAME_W;
  localparam int SH  = pfa_pkg::FRAME_SHIFT;
  localparam int AW  = pfa_pkg::WORD_AW;
  localparam int BW  = pfa_pkg::BIT_W;
  localparam int CW  = pfa_pkg::COUNT_W;
  localparam int FBW = pfa_pkg::ADDR_W - SH;
  localparam int EBW = pfa_pkg::ADDR_W + 1 - SH;

  pfa_pkg::state_t  state_r, state_nxt;
  pfa_pkg::cmd_t    cmd_r, cmd_nxt;
  pfa_pkg::op_t     op_r, op_nxt;
  pfa_pkg::status_t status_r, status_nxt;

  logic [pfa_pkg::ADDR_W-1:0]  base_r, base_nxt;
  logic [pfa_pkg::ADDR_W-1:0]  s_r, s_nxt;
  logic [pfa_pkg::ADDR_W:0]    em1_r, em1_nxt;
  logic                        lenz_r, lenz_nxt;
  logic [pfa_pkg::FS_W-1:0]    fs_r, fs_nxt;
  logic [pfa_pkg::LIM_W:0]     fs_sum;

  logic [FW-1:0]   f0_r, f0_nxt;
  logic [FW-1:0]   f1_r, f1_nxt;
  logic [AW:0]     rd_w_r, rd_w_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            pv_r, pv_nxt;
  logic [AW-1:0]   pw_r, pw_nxt;
  logic            chg_v_r, chg_v_nxt;
  logic            chg_dec_r, chg_dec_nxt;
  logic [pfa_pkg::WORD_BITS-1:0] chg_r, chg_nxt;
  logic            any_chg_r, any_chg_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [pfa_pkg::FADDR_W-1:0] addr_r, addr_nxt;

  logic [AW-1:0]   w0, w1;
  logic [BW-1:0]   lo, hi;
  logic [FW-1:0]   f1_calc;
  logic            base_in, ok_rel, ok_res;
  logic [BW:0]     chg_cnt;
  pfa_pkg::word_res_t wres;

  // Shared per-word unit
  pfa_word_unit u_word (
    .op   (op_r),
    .word (mem_rd_data),
    .lo   (lo),
    .hi   (hi),
    .res  (wres)
  );

  assign w0 = f0_r[FW-1:BW];
  assign w1 = f1_r[FW-1:BW];
  assign lo = (pw_r == w0) ? f0_r[BW-1:0] : '0;
  assign hi = (pw_r == w1) ? f1_r[BW-1:0] : '1;

  // Range bounds from the latched request
  assign fs_sum  = {1'b0, low_reserve_limit} + (pfa_pkg::LIM_W + 1)'(pfa_pkg::FRAME_BYTES - 1);
  assign base_in = base_r[pfa_pkg::ADDR_W-1:SH] < FBW'(pfa_pkg::FRAME_COUNT);
  assign f1_calc = (em1_r[pfa_pkg::ADDR_W:SH] < EBW'(pfa_pkg::FRAME_COUNT)) ?
                   em1_r[SH+FW-1:SH] : FW'(pfa_pkg::FRAME_COUNT - 1);
  assign ok_rel  = !lenz_r && (em1_r >= {1'b0, s_r}) &&
                   (s_r[pfa_pkg::ADDR_W-1:SH] < FBW'(pfa_pkg::FRAME_COUNT));
  assign ok_res  = !lenz_r && base_in;
  assign chg_cnt = (BW + 1)'($countones(chg_r));

  assign rsp.frame_address = addr_r;
  assign rsp.status        = status_r;
  assign rsp.free_count    = count_r;

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfa_pkg::S_CLEAR;
      clr_r   <= '0;
      pv_r    <= 1'b0;
      chg_v_r <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pv_r    <= pv_nxt;
      chg_v_r <= chg_v_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    op_r      <= op_nxt;
    status_r  <= status_nxt;
    base_r    <= base_nxt;
    s_r       <= s_nxt;
    em1_r     <= em1_nxt;
    lenz_r    <= lenz_nxt;
    fs_r      <= fs_nxt;
    f0_r      <= f0_nxt;
    f1_r      <= f1_nxt;
    rd_w_r    <= rd_w_nxt;
    pw_r      <= pw_nxt;
    chg_dec_r <= chg_dec_nxt;
    chg_r     <= chg_nxt;
    any_chg_r <= any_chg_nxt;
    addr_r    <= addr_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    op_nxt      = op_r;
    status_nxt  = status_r;
    base_nxt    = base_r;
    s_nxt       = s_r;
    em1_nxt     = em1_r;
    lenz_nxt    = lenz_r;
    fs_nxt      = fs_r;
    f0_nxt      = f0_r;
    f1_nxt      = f1_r;
    rd_w_nxt    = rd_w_r;
    clr_nxt     = clr_r;
    pv_nxt      = 1'b0;
    pw_nxt      = rd_w_r[AW-1:0];
    chg_v_nxt   = 1'b0;
    chg_dec_nxt = chg_dec_r;
    chg_nxt     = chg_r;
    any_chg_nxt = any_chg_r;
    addr_nxt    = addr_r;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    mem         = '0;

    // Fold the last word's change into the free count
    count_nxt = count_r;
    if (chg_v_r) begin
      if (chg_dec_r) begin
        count_nxt = count_r - CW'(chg_cnt);
      end else begin
        count_nxt = count_r + CW'(chg_cnt);
      end
    end

    unique case (state_r)
      // Preset every bitmap word to used
      pfa_pkg::S_CLEAR: begin
        mem.wr_en   = 1'b1;
        mem.wr_addr = clr_r;
        mem.wr_data = '1;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == AW'(pfa_pkg::WORDS - 1)) begin
          state_nxt = pfa_pkg::S_IDLE;
        end
      end

      // Take a request and precompute its bounds
      pfa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd_nxt  = req.command;
          base_nxt = req.address;
          s_nxt    = (req.address < pfa_pkg::ADDR_W'(low_reserve_limit)) ?
                     pfa_pkg::ADDR_W'(low_reserve_limit) : req.address;
          em1_nxt  = {1'b0, req.address} + {1'b0, req.length} -
                     (pfa_pkg::ADDR_W + 1)'(1);
          lenz_nxt = (req.length == '0);
          fs_nxt   = fs_sum[pfa_pkg::LIM_W:SH];
          state_nxt = pfa_pkg::S_SETUP;
        end
      end

      // Decide the frame window and the operation
      pfa_pkg::S_SETUP: begin
        status_nxt  = pfa_pkg::STAT_DONE;
        any_chg_nxt = 1'b0;
        addr_nxt    = '0;
        state_nxt   = pfa_pkg::S_SCAN;
        case (cmd_r)
          pfa_pkg::CMD_ALLOC: begin
            op_nxt = pfa_pkg::OP_ALLOC;
            f0_nxt = fs_r[FW-1:0];
            f1_nxt = FW'(pfa_pkg::FRAME_COUNT - 1);
            if (fs_r >= pfa_pkg::FS_W'(pfa_pkg::FRAME_COUNT)) begin
              status_nxt = pfa_pkg::STAT_OOM;
              state_nxt  = pfa_pkg::S_REPLY;
            end
          end
          pfa_pkg::CMD_FREE: begin
            op_nxt = pfa_pkg::OP_SET_FREE;
            f0_nxt = base_r[SH+FW-1:SH];
            f1_nxt = base_r[SH+FW-1:SH];
            if (!base_in) begin
              status_nxt = pfa_pkg::STAT_IGNORED;
              state_nxt  = pfa_pkg::S_REPLY;
            end
          end
          pfa_pkg::CMD_RELEASE: begin
            op_nxt = pfa_pkg::OP_SET_FREE;
            f0_nxt = s_r[SH+FW-1:SH];
            f1_nxt = f1_calc;
            if (!ok_rel) begin
              status_nxt = pfa_pkg::STAT_IGNORED;
              state_nxt  = pfa_pkg::S_REPLY;
            end
          end
          default: begin
            op_nxt = pfa_pkg::OP_SET_USED;
            f0_nxt = base_r[SH+FW-1:SH];
            f1_nxt = f1_calc;
            if (!ok_res) begin
              status_nxt = pfa_pkg::STAT_IGNORED;
              state_nxt  = pfa_pkg::S_REPLY;
            end
          end
        endcase
        rd_w_nxt    = {1'b0, f0_nxt[FW-1:BW]};
        chg_dec_nxt = (op_nxt != pfa_pkg::OP_SET_FREE);
      end

      // Stream words through the unit, one read issued per cycle
      pfa_pkg::S_SCAN: begin
        if (rd_w_r <= {1'b0, w1}) begin
          mem.rd_en   = 1'b1;
          mem.rd_addr = rd_w_r[AW-1:0];
          rd_w_nxt    = rd_w_r + (AW + 1)'(1);
          pv_nxt      = 1'b1;
        end
        if (pv_r) begin
          if (op_r == pfa_pkg::OP_ALLOC) begin
            if (wres.found) begin
              mem.wr_en   = 1'b1;
              mem.wr_addr = pw_r;
              mem.wr_data = wres.new_word;
              chg_v_nxt   = 1'b1;
              chg_nxt     = wres.changed;
              addr_nxt    = pfa_pkg::FADDR_W'({pw_r, wres.idx, SH'(0)});
              state_nxt   = pfa_pkg::S_FINISH;
            end else if (pw_r == w1) begin
              status_nxt = pfa_pkg::STAT_OOM;
              state_nxt  = pfa_pkg::S_FINISH;
            end
          end else begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = pw_r;
            mem.wr_data = wres.new_word;
            chg_v_nxt   = 1'b1;
            chg_nxt     = wres.changed;
            any_chg_nxt = any_chg_r | (|wres.changed);
            if (pw_r == w1) begin
              state_nxt = pfa_pkg::S_FINISH;
            end
          end
        end
      end

      // Let the count settle; a free of a free frame is ignored
      pfa_pkg::S_FINISH: begin
        if (cmd_r == pfa_pkg::CMD_FREE && !any_chg_r) begin
          status_nxt = pfa_pkg::STAT_IGNORED;
        end
        state_nxt = pfa_pkg::S_REPLY;
      end

      // Hold the result until the output stage takes it
      pfa_pkg::S_REPLY: begin
        rsp_valid = 1'b1;
        if (rsp_take) begin
          state_nxt = pfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pfa_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/pfa_checker.sv
module pfa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input pfa_pkg::pfa_req_t in_data,
  input logic              out_valid,
  input logic              out_ready,
  input pfa_pkg::pfa_rsp_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only a successful alloc carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != pfa_pkg::STAT_DONE |-> out_data.frame_address == '0)
    else $error("address on a failed or ignored request");

  // Handed-out addresses are frame aligned
  a_addr_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.frame_address[pfa_pkg::FRAME_SHIFT-1:0] == '0)
    else $error("unaligned frame address");

  // A taken request keeps the block busy for the next cycles
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request taken while busy");

endmodule

bind physical_frame_bitmap_allocator_top pfa_checker u_pfa_checker (.*);

FILE: test/tb_physical_frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps

module tb_physical_frame_bitmap_allocator_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int WINDOW_FRAMES  = 320;
  localparam int STRETCH_ITEMS  = 87;
  localparam longint unsigned MEM_BYTES =
    longint'(pfa_pkg::FRAME_COUNT) * pfa_pkg::FRAME_BYTES;

  // Predicts every result from a private copy of the bitmap, count and limit
  class frame_alloc_scoreboard;
    bit [pfa_pkg::WORD_BITS-1:0] used_words [pfa_pkg::WORDS];
    int unsigned                 free_total;
    bit [pfa_pkg::LIM_W-1:0]     reserve_limit;
    pfa_pkg::pfa_rsp_t           expected_q[$];
    int unsigned                 mismatches;

    function new();
      foreach (used_words[i]) used_words[i] = '1;
      free_total    = 0;
      reserve_limit = pfa_pkg::LIM_RESET;
      mismatches    = 0;
    endfunction

    function void set_limit(bit [pfa_pkg::LIM_W-1:0] value);
      reserve_limit = value;
    endfunction

    function bit frame_is_used(longint unsigned f);
      return used_words[int'(f >> pfa_pkg::BIT_W)][int'(f % pfa_pkg::WORD_BITS)];
    endfunction

    // Flip one mark; the count follows only a real change
    function void mark_frame(longint unsigned f, bit used);
      if (frame_is_used(f) != used) begin
        used_words[int'(f >> pfa_pkg::BIT_W)][int'(f % pfa_pkg::WORD_BITS)] = used;
        if (used) free_total--;
        else free_total++;
      end
    endfunction

    function void mark_span(longint unsigned f0, longint unsigned f1, bit used);
      for (longint unsigned f = f0; f <= f1; f++) mark_frame(f, used);
    endfunction

    function pfa_pkg::pfa_rsp_t note_request(pfa_pkg::pfa_req_t req);
      longint unsigned base, len, f, f1, cut;
      bit ok;
      pfa_pkg::pfa_rsp_t rsp;
      base = 64'(req.address);
      len  = 64'(req.length);
      rsp  = '0;
      rsp.status = pfa_pkg::STAT_DONE;
      case (req.command)
        pfa_pkg::CMD_ALLOC: begin
          // First fit from the frame at or above the limit, skipping full words
          f = (longint'(reserve_limit) + pfa_pkg::FRAME_BYTES - 1) / pfa_pkg::FRAME_BYTES;
          while (f < pfa_pkg::FRAME_COUNT) begin
            if (f % pfa_pkg::WORD_BITS == 0 && &used_words[int'(f >> pfa_pkg::BIT_W)])
              f += pfa_pkg::WORD_BITS;
            else if (!frame_is_used(f)) break;
            else f++;
          end
          if (f < pfa_pkg::FRAME_COUNT) begin
            mark_frame(f, 1'b1);
            rsp.frame_address = pfa_pkg::FADDR_W'(f * pfa_pkg::FRAME_BYTES);
          end else begin
            rsp.status = pfa_pkg::STAT_OOM;
          end
        end
        pfa_pkg::CMD_FREE: begin
          f = base / pfa_pkg::FRAME_BYTES;
          if (f >= pfa_pkg::FRAME_COUNT || !frame_is_used(f))
            rsp.status = pfa_pkg::STAT_IGNORED;
          else mark_frame(f, 1'b0);
        end
        pfa_pkg::CMD_RELEASE: begin
          // Clip to the limit below and the memory size above
          ok = (len != 0);
          if (ok && base < reserve_limit) begin
            cut = reserve_limit - base;
            if (len <= cut) begin
              ok = 1'b0;
            end else begin
              base += cut;
              len  -= cut;
            end
          end
          if (ok && base >= MEM_BYTES) ok = 1'b0;
          if (ok) begin
            if (base + len > MEM_BYTES) len = MEM_BYTES - base;
            mark_span(base / pfa_pkg::FRAME_BYTES, (base + len - 1) / pfa_pkg::FRAME_BYTES,
                      1'b0);
          end else begin
            rsp.status = pfa_pkg::STAT_IGNORED;
          end
        end
        default: begin
          f = base / pfa_pkg::FRAME_BYTES;
          if (len == 0 || f >= pfa_pkg::FRAME_COUNT) begin
            rsp.status = pfa_pkg::STAT_IGNORED;
          end else begin
            f1 = (base + len - 1) / pfa_pkg::FRAME_BYTES;
            if (f1 >= pfa_pkg::FRAME_COUNT) f1 = pfa_pkg::FRAME_COUNT - 1;
            mark_span(f, f1, 1'b1);
          end
        end
      endcase
      rsp.free_count = pfa_pkg::COUNT_W'(free_total);
      expected_q.push_back(rsp);
      return rsp;
    endfunction

    function void check_result(pfa_pkg::pfa_rsp_t got);
      pfa_pkg::pfa_rsp_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: addr %h status %0d count %0d",
                   got.frame_address, got.status, got.free_count);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.frame_address !== want.frame_address || got.status !== want.status ||
          got.free_count !== want.free_count) begin
        if (mismatches < 10)
          $display("mismatch: expected addr %h status %0d count %0d, got addr %h status %0d count %0d",
                   want.frame_address, want.status, want.free_count,
                   got.frame_address, got.status, got.free_count);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  pfa_pkg::pfa_req_t           in_data     = '0;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;
  pfa_pkg::pfa_rsp_t           out_data;
  logic                        cfg_wr_en   = 1'b0;
  logic [pfa_pkg::LIM_W-1:0]   cfg_wr_data = '0;

  frame_alloc_scoreboard        sb;
  logic [pfa_pkg::FADDR_W-1:0]  held_frames[$];
  int unsigned                  window_frame;
  int                           tx_idle_pct = 0;
  int                           rx_idle_pct = 0;
  int unsigned                  hold_token  = 0;
  int unsigned                  hold_seen   = 0;
  int unsigned                  hold_left   = 0;
  int unsigned                  quiet_cycles = 0;

  physical_frame_bitmap_allocator_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check results and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one request, hold it until taken, then predict its result
  task automatic send_request(input pfa_pkg::pfa_req_t req);
    pfa_pkg::pfa_rsp_t rsp;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp = sb.note_request(req);
    if (req.command == pfa_pkg::CMD_ALLOC && rsp.status == pfa_pkg::STAT_DONE)
      held_frames.push_back(rsp.frame_address);
  endtask

  task automatic send_cmd(input pfa_pkg::cmd_t cmd,
                          input logic [pfa_pkg::ADDR_W-1:0] address,
                          input logic [pfa_pkg::LEN_W-1:0] length);
    pfa_pkg::pfa_req_t req;
    req.command = cmd;
    req.address = address;
    req.length  = length;
    send_request(req);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [pfa_pkg::LIM_W-1:0] value);
    int unsigned lim_frame;
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_limit(value);
    lim_frame    = 32'(value >> pfa_pkg::FRAME_SHIFT);
    window_frame = (lim_frame > 16) ? lim_frame - 16 : 0;
  endtask

  // Address near the limit, aligned or not
  function automatic logic [pfa_pkg::ADDR_W-1:0] window_address();
    logic [pfa_pkg::ADDR_W-1:0] a;
    a = 32'((window_frame + $urandom_range(WINDOW_FRAMES - 1)) * pfa_pkg::FRAME_BYTES);
    if ($urandom_range(1)) a += $urandom_range(pfa_pkg::FRAME_BYTES - 1);
    return a;
  endfunction

  // Mostly a few frames, now and then zero or a longer span
  function automatic logic [pfa_pkg::LEN_W-1:0] span_length();
    int unsigned roll;
    roll = $urandom_range(11);
    if (roll == 0) return '0;
    if (roll == 1) return $urandom_range(1, 96 * pfa_pkg::FRAME_BYTES);
    return $urandom_range(1, 8 * pfa_pkg::FRAME_BYTES);
  endfunction

  function automatic pfa_pkg::pfa_req_t random_request();
    pfa_pkg::pfa_req_t req;
    int unsigned       roll, pick;
    req.command = pfa_pkg::CMD_ALLOC;
    req.address = $urandom;
    req.length  = $urandom;
    roll = $urandom_range(99);
    if (roll < 30) begin
      req.command = pfa_pkg::CMD_ALLOC;
    end else if (roll < 50 && held_frames.size() != 0) begin
      // Hand back a frame that an earlier alloc returned
      pick = $urandom_range(held_frames.size() - 1);
      req.command = pfa_pkg::CMD_FREE;
      req.address = {3'b000, held_frames[pick]} | $urandom_range(pfa_pkg::FRAME_BYTES - 1);
      held_frames.delete(pick);
    end else if (roll < 62) begin
      req.command = pfa_pkg::CMD_RELEASE;
      req.address = window_address();
      req.length  = span_length();
    end else if (roll < 72) begin
      req.command = pfa_pkg::CMD_RESERVE;
      req.address = window_address();
      req.length  = span_length();
    end else if (roll < 85) begin
      req.command = pfa_pkg::CMD_FREE;
      req.address = window_address();
    end else begin
      req.command = pfa_pkg::cmd_t'($urandom_range(3));
    end
    return req;
  endfunction

  task automatic run_stretch(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < STRETCH_ITEMS; i++) begin
      if (i == STRETCH_ITEMS / 2) drain_results();
      send_request(random_request());
    end
  endtask

  task automatic run_directed();
    // Alloc with no free frame straight after reset
    send_cmd(pfa_pkg::CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    // Single frees: below the limit, twice, beyond memory, last frame
    send_cmd(pfa_pkg::CMD_FREE,    32'h0000_0000, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_FREE,    32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(pfa_pkg::CMD_FREE,    32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_FREE,    32'h2000_0000, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_FREE,    32'h1FFF_FFFF, 32'h0000_0000);
    // Release: zero length, clipped away, unaligned ends, beyond memory, past the end
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h0010_0000, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h0000_0000, 32'h0010_0000);
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h0008_0000, 32'h0008_3001);
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h2000_0000, 32'h0000_1000);
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h1FFF_F800, 32'hFFFF_FFFF);
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h0012_3456, 32'h0000_0010);
    // Alloc ignores its address and length
    send_cmd(pfa_pkg::CMD_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Reserve: zero length, beyond memory, past the end, straddling two frames
    send_cmd(pfa_pkg::CMD_RESERVE, 32'h0010_1000, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(pfa_pkg::CMD_RESERVE, 32'h1FFF_F000, 32'hFFFF_FFFF);
    send_cmd(pfa_pkg::CMD_RESERVE, 32'h0010_2FFF, 32'h0000_0002);
    send_cmd(pfa_pkg::CMD_RESERVE, 32'h0010_0000, 32'h0000_1000);
    // Allocs above the limit, with a free of a handed-out frame in between
    send_cmd(pfa_pkg::CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_FREE,    32'h0010_0FFF, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    // Memory above the limit released, then all of memory reserved
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(pfa_pkg::CMD_RESERVE, 32'h0000_0000, 32'h2000_0000);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_limit(pfa_pkg::LIM_RESET);
    run_directed();

    // No limit: every frame free, frame zero handed out, all taken back
    drain_results();
    write_limit('0);
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(pfa_pkg::CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_RESERVE, 32'h0000_0000, 32'hFFFF_FFFF);
    run_stretch(12, 77);

    // Limit at the top of memory: nothing can be handed out or released
    drain_results();
    write_limit(pfa_pkg::LIM_W'(MEM_BYTES));
    send_cmd(pfa_pkg::CMD_ALLOC,   32'h0000_0000, 32'h0000_0000);
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(pfa_pkg::CMD_RELEASE, 32'h1FFF_F000, 32'h0000_1000);

    drain_results();
    write_limit(pfa_pkg::LIM_W'(32'h000C_D400));
    run_stretch(77, 12);

    // Unaligned limit; start with a long result stall so the input backs up
    drain_results();
    write_limit(pfa_pkg::LIM_W'($urandom_range(32'h0100_0000)) | pfa_pkg::LIM_W'(1));
    hold_token++;
    run_stretch(0, 0);

    drain_results();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
